@@ rtl/fpcp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fpcp_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_STEPS_MAX = 24;
   localparam int DEG_FULL         = 46080;
   localparam int DEG_HALF         = 23040;
   localparam int DEG_QUARTER      = 11520;
   localparam int PITCH_LIMIT      = 15360;
   localparam int ONE_Q14          = 16384;
   localparam int RAD_PER_UNIT     = 146409;
   localparam int CORDIC_GAIN      = 163008219;

   typedef enum logic [2:0] {
      CMD_YAW   = 3'd0,
      CMD_PITCH = 3'd1,
      CMD_FWD   = 3'd2,
      CMD_RIGHT = 3'd3,
      CMD_UP    = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORD_YAW,
      ST_CORD_PITCH,
      ST_VIEW_X,
      ST_VIEW_Z,
      ST_MOVE_X,
      ST_MOVE_Z,
      ST_DONE
   } state_type;

   // arctangent table in Q30
   function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
      logic signed [31:0] r;
      case (idx)
         5'd0:  r = 32'sd843314857;
         5'd1:  r = 32'sd497837829;
         5'd2:  r = 32'sd263043837;
         5'd3:  r = 32'sd133525159;
         5'd4:  r = 32'sd67021687;
         5'd5:  r = 32'sd33543516;
         5'd6:  r = 32'sd16775851;
         5'd7:  r = 32'sd8388437;
         5'd8:  r = 32'sd4194283;
         5'd9:  r = 32'sd2097149;
         5'd10: r = 32'sd1048576;
         5'd11: r = 32'sd524288;
         5'd12: r = 32'sd262144;
         5'd13: r = 32'sd131072;
         5'd14: r = 32'sd65536;
         5'd15: r = 32'sd32768;
         5'd16: r = 32'sd16384;
         5'd17: r = 32'sd8192;
         5'd18: r = 32'sd4096;
         5'd19: r = 32'sd2048;
         5'd20: r = 32'sd1024;
         5'd21: r = 32'sd512;
         5'd22: r = 32'sd256;
         5'd23: r = 32'sd128;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/fpcp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface fpcp_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        cmd;
   logic signed [15:0] amount;
   modport source (output valid, cmd, amount, input ready);
   modport sink   (input valid, cmd, amount, output ready);
endinterface

interface fpcp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [15:0] view_x;
   logic signed [15:0] view_y;
   logic signed [15:0] view_z;
   modport source (output valid, pos_x, pos_y, pos_z, view_x, view_y, view_z,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, view_x, view_y, view_z,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/fpcp_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Rotation-mode CORDIC, one micro-rotation per cycle.
// done pulses for one cycle once the last micro-rotation is registered.
module fpcp_cordic #(
   parameter int CORDIC_STEPS = fpcp_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [16:0] angle,
   output logic                    done,
   output logic signed [15:0]      cos_q14,
   output logic signed [15:0]      sin_q14
);
   import fpcp_pkg::*;

   localparam int CW = $clog2(CORDIC_STEPS + 1);

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [35:0] z_ff, z_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               flip_ff, flip_in;
   logic signed [16:0] red;
   logic               flip_now;
   logic signed [33:0] dx, dy, xf, yf;
   logic signed [33:0] xr, yr;

   // fold angle into the right half plane
   always_comb begin
      red      = angle;
      flip_now = 1'b0;
      if (angle > 17'(DEG_QUARTER)) begin
         red = angle - 17'(DEG_HALF);
         flip_now = 1'b1;
      end else if (angle < -17'(DEG_QUARTER)) begin
         red = angle + 17'(DEG_HALF);
         flip_now = 1'b1;
      end
   end

   always_comb begin
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; flip_in = flip_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = 34'(CORDIC_GAIN);
         y_in = '0;
         z_in = 36'(red) * 36'sd146409;
         cnt_in = '0;
         busy_in = 1'b1;
         flip_in = flip_now;
      end else if (busy_ff) begin
         // advance one micro-rotation
         if (!z_ff[35]) begin
            x_in = x_ff - dx; y_in = y_ff + dy;
            z_in = z_ff - 36'(atan_q30(5'(cnt_ff)));
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy;
            z_in = z_ff + 36'(atan_q30(5'(cnt_ff)));
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; flip_ff <= flip_in;
   end

   // round to Q1.14 and clamp
   always_comb begin
      xf = flip_ff ? -x_ff : x_ff;
      yf = flip_ff ? -y_ff : y_ff;
      xr = (xf + 34'sd8192) >>> 14;
      yr = (yf + 34'sd8192) >>> 14;
      if (xr > 34'sd16384) cos_q14 = 16'sd16384;
      else if (xr < -34'sd16384) cos_q14 = -16'sd16384;
      else cos_q14 = xr[15:0];
      if (yr > 34'sd16384) sin_q14 = 16'sd16384;
      else if (yr < -34'sd16384) sin_q14 = -16'sd16384;
      else sin_q14 = yr[15:0];
   end

   assign done = done_ff;
endmodule
`default_nettype wire

@@ rtl/first_person_camera_pose.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Free-fly camera pose unit.
// req channel: cmd (0 yaw, 1 pitch, 2 forward, 3 right, 4 up) and a signed
// amount (degrees*128 or units*256). rsp channel: position (3 x 32 bit) and
// unit view vector in Q1.14, one response per request.
// One request at a time: req.ready is high only while idle with no response
// pending, or while the pending response transfers in that same cycle.
// Rotations run the shared CORDIC twice (yaw then pitch), then the
// ST_VIEW_X and ST_VIEW_Z multiply states, before the response is
// registered. Forward/right moves run one CORDIC pass on yaw, but skip
// it before the first rotation and at exactly ninety degrees pitch; up
// and unknown commands need no CORDIC pass.
// The response register holds its data until rsp.ready; a stalled
// receiver holds the block busy.
// Reset (synchronous) returns the pose to origin, view (0,0,-1),
// yaw and pitch zero.
module first_person_camera_pose #(
   parameter int CORDIC_STEPS = fpcp_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   fpcp_req_if.sink  req,
   fpcp_rsp_if.source rsp
);
   import fpcp_pkg::*;

   state_type          state_ff, state_in;
   logic [15:0]        yaw_ff, yaw_in;
   logic signed [14:0] pitch_ff, pitch_in;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [15:0] view_ff [3];
   logic signed [15:0] view_in [3];
   logic               aimed_ff, aimed_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic signed [15:0] amt_ff, amt_in;
   logic signed [15:0] cy_ff, cy_in, sy_ff, sy_in;
   logic signed [1:0]  sg_ff, sg_in;
   logic               rv_ff, rv_in;

   logic               c_start, c_done;
   logic signed [16:0] c_angle;
   logic signed [15:0] c_cos, c_sin;

   logic signed [15:0] ma, mb;
   logic signed [31:0] prod;
   logic signed [31:0] prnd;
   logic signed [15:0] prod_cl;
   logic signed [16:0] yaw_s;
   logic signed [17:0] ysum;
   logic signed [16:0] psum;
   logic signed [14:0] pabs;
   logic signed [32:0] padd;
   logic [1:0]         pk;
   logic signed [31:0] psat;

   fpcp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(c_start), .angle(c_angle),
      .done(c_done), .cos_q14(c_cos), .sin_q14(c_sin)
   );

   // shared multiplier with Q14 rounding
   always_comb begin
      prod = ma * mb;
      prnd = (prod + 32'sd8192) >>> 14;
      if (prnd > 32'sd16384) prod_cl = 16'sd16384;
      else if (prnd < -32'sd16384) prod_cl = -16'sd16384;
      else prod_cl = prnd[15:0];
   end

   // shared saturating position adder
   always_comb begin
      padd = 33'(pos_ff[pk]) + 33'(prnd);
      if (padd > 33'sd2147483647) psat = 32'sh7fffffff;
      else if (padd < -33'sd2147483648) psat = 32'sh80000000;
      else psat = padd[31:0];
   end

   always_comb begin
      yaw_s = (yaw_ff >= 16'(DEG_HALF)) ? 17'(yaw_ff) - 17'(DEG_FULL)
                                        : 17'(yaw_ff);
      ysum  = 18'(yaw_ff) + 18'(amt_ff);
      psum  = 17'(pitch_ff) + 17'(amt_ff);
      pabs  = pitch_ff[14] ? -pitch_ff : pitch_ff;
   end

   always_comb begin
      state_in = state_ff;
      yaw_in = yaw_ff; pitch_in = pitch_ff; aimed_in = aimed_ff;
      pos_in = pos_ff; view_in = view_ff;
      cmd_in = cmd_ff; amt_in = amt_ff;
      cy_in = cy_ff; sy_in = sy_ff; sg_in = sg_ff;
      rv_in = rv_ff && !rsp.ready;
      c_start = 1'b0; c_angle = yaw_s;
      ma = '0; mb = '0; pk = 2'd0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && (!rv_ff || rsp.ready)) begin
               cmd_in = req.cmd; amt_in = req.amount;
               state_in = ST_DONE;
               case (req.cmd)
                  CMD_YAW, CMD_PITCH: state_in = ST_CORD_YAW;
                  CMD_FWD, CMD_RIGHT: state_in = ST_MOVE_X;
                  CMD_UP: state_in = ST_MOVE_Z;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CORD_YAW: begin
            // first update angles; the yaw pass starts in ST_CORD_PITCH
            if (cmd_ff == CMD_YAW) begin
               if (ysum[17]) yaw_in = 16'(ysum + 18'(DEG_FULL));
               else if (ysum >= 18'(DEG_FULL)) yaw_in = 16'(ysum - 18'(DEG_FULL));
               else yaw_in = ysum[15:0];
            end else begin
               if (psum > 17'(PITCH_LIMIT)) pitch_in = 15'(PITCH_LIMIT);
               else if (psum < -17'(PITCH_LIMIT)) pitch_in = -15'(PITCH_LIMIT);
               else pitch_in = psum[14:0];
            end
            state_in = ST_CORD_PITCH;
            cmd_in = 3'(CMD_PITCH) | 3'b100; // mark rotation path
         end
         ST_CORD_PITCH: begin
            if (cmd_ff[2]) begin
               c_start = 1'b1; c_angle = yaw_s;
               cmd_in = 3'(CMD_YAW);
            end else if (c_done) begin
               if (cmd_ff == 3'(CMD_YAW)) begin
                  cy_in = c_cos; sy_in = c_sin;
                  c_start = 1'b1; c_angle = 17'(pitch_ff);
                  cmd_in = 3'(CMD_PITCH);
               end else begin
                  view_in[1] = c_sin;
                  amt_in = c_cos;
                  state_in = ST_VIEW_X;
               end
            end
         end
         ST_VIEW_X: begin
            ma = amt_ff; mb = cy_ff;
            view_in[0] = prod_cl;
            state_in = ST_VIEW_Z;
         end
         ST_VIEW_Z: begin
            // negate before rounding so ties round the same way
            ma = amt_ff; mb = -sy_ff;
            view_in[2] = prod_cl;
            aimed_in = 1'b1;
            state_in = ST_DONE;
         end
         ST_MOVE_X: begin
            // resolve horizontal direction, then multiply and add
            if (cmd_ff[2]) begin
               if (c_done) begin
                  if (cmd_ff[0]) begin
                     cy_in = sg_ff[1] ? c_sin : -c_sin;
                     sy_in = sg_ff[1] ? c_cos : -c_cos;
                  end else begin
                     cy_in = sg_ff[1] ? -c_cos : c_cos;
                     sy_in = sg_ff[1] ? c_sin : -c_sin;
                  end
                  cmd_in = 3'b000;
               end
            end else if (cmd_ff == 3'b000 || cmd_ff == 3'b001) begin
               ma = amt_ff; mb = cy_ff; pk = 2'd0;
               pos_in[0] = psat;
               state_in = ST_MOVE_Z;
               cmd_in = 3'b001;
            end else if (!aimed_ff) begin
               cy_in = (cmd_ff == CMD_RIGHT) ? -16'sd16384 : 16'sd0;
               sy_in = (cmd_ff == CMD_RIGHT) ? 16'sd0 : -16'sd16384;
               cmd_in = 3'b000;
            end else if (pabs == 15'(DEG_QUARTER)) begin
               state_in = ST_DONE;
            end else begin
               sg_in = (pabs < 15'(DEG_QUARTER)) ? 2'sd1 : -2'sd1;
               c_start = 1'b1; c_angle = yaw_s;
               cmd_in = (cmd_ff == CMD_RIGHT) ? 3'b101 : 3'b100;
            end
         end
         ST_MOVE_Z: begin
            if (cmd_ff == CMD_UP) begin
               ma = amt_ff; mb = 16'sd16384; pk = 2'd1;
               pos_in[1] = psat;
            end else begin
               ma = amt_ff; mb = sy_ff; pk = 2'd2;
               pos_in[2] = psat;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         yaw_ff <= '0; pitch_ff <= '0; aimed_ff <= 1'b0; rv_ff <= 1'b0;
         pos_ff <= '{default: '0};
         view_ff <= '{16'sd0, 16'sd0, -16'sd16384};
      end else begin
         state_ff <= state_in;
         yaw_ff <= yaw_in; pitch_ff <= pitch_in; aimed_ff <= aimed_in;
         rv_ff <= rv_in;
         pos_ff <= pos_in; view_ff <= view_in;
      end
      cmd_ff <= cmd_in; amt_ff <= amt_in;
      cy_ff <= cy_in; sy_ff <= sy_in; sg_ff <= sg_in;
   end

   assign req.ready  = (state_ff == ST_IDLE) && (!rv_ff || rsp.ready);
   assign rsp.valid  = rv_ff;
   assign rsp.pos_x  = pos_ff[0];
   assign rsp.pos_y  = pos_ff[1];
   assign rsp.pos_z  = pos_ff[2];
   assign rsp.view_x = view_ff[0];
   assign rsp.view_y = view_ff[1];
   assign rsp.view_z = view_ff[2];
endmodule
`default_nettype wire

@@ rtl/fpcp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fpcp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [15:0] view_x,
   input wire logic signed [15:0] view_y,
   input wire logic signed [15:0] view_z
);
   // no new request taken in the cycle right after a transfer in
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("double accept");
   // a response never waits while a new request is taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready) else $error("overlap");
   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(view_x)
      && $stable(view_y) && $stable(view_z)) else $error("rsp dropped");
   // view_y stays in Q1.14 unit range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> view_y <= 16'sd16384 && view_y >= -16'sd16384)
      else $error("view out of range");
endmodule

bind first_person_camera_pose fpcp_checker u_fpcp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .view_x(rsp.view_x), .view_y(rsp.view_y), .view_z(rsp.view_z)
);
`default_nettype wire
